FILE: design/rmdl_pkg.sv
package rmdl_pkg;

    localparam int ADDR_W = 9;
    localparam int DATA_W = 8;
    localparam int RAM_DEPTH = 512;
    localparam int RAM_AW = $clog2(RAM_DEPTH);

    localparam int LAMP_ROWS = 9;
    localparam int LAMP_RW = $clog2(LAMP_ROWS);
    localparam int LAMP_DW = 2 * DATA_W;

    localparam logic [LAMP_RW-1:0] PLAYER_ROW = LAMP_RW'(8);
    localparam logic [4:0] PLAYER_COL = 5'd16;

    localparam logic REQ_READ = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [ADDR_W-1:0] SCORE_END = 9'h010;
    localparam logic [ADDR_W-1:0] MATCH_ADDR = 9'h01c;
    localparam logic [ADDR_W-1:0] CREDIT_ADDR = 9'h01d;
    localparam logic [ADDR_W-1:0] LAMP_BASE = 9'h030;
    localparam logic [ADDR_W-1:0] LAMP_END = 9'h040;
    localparam logic [3:0] PLAYER_ON_CODE = 4'h8;
    localparam logic [7:0] PLAYER_BIT0 = 8'h08;
    localparam logic [5:0] SCORE_POS_TOP = 6'd30;
    localparam logic [5:0] MATCH_POS = 6'd32;
    localparam logic [5:0] CREDIT_POS = 6'd34;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              disp_update;
        logic [5:0]        disp_position;
        logic [3:0]        disp_first_digit;
        logic [3:0]        disp_second_digit;
        logic              lamp_update;
        logic [4:0]        lamp_column;
        logic [DATA_W-1:0] lamp_value;
        logic              lamp_pair;
        logic [DATA_W-1:0] lamp_upper_value;
    } rsp_t;

    typedef struct packed {
        logic               en;
        logic [LAMP_RW-1:0] row;
        logic [LAMP_DW-1:0] data;
    } lamp_wr_t;

    // The address is folded into the window by repeated subtraction; the
    // window is at least one eighth of the address space.
    function automatic logic [ADDR_W-1:0] reduce_addr(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] v;
        v = a;
        for (int i = 0; i < 8; i++) begin
            if ({1'b0, v} >= (ADDR_W + 1)'(RAM_DEPTH)) begin
                v = v - ADDR_W'(RAM_DEPTH);
            end
        end
        return v;
    endfunction

    // Row 8 holds the player-up column; row c holds columns c and c+8.
    function automatic logic [LAMP_RW-1:0] lamp_row(input logic [ADDR_W-1:0] a);
        logic [LAMP_RW-1:0] r;
        if (a < SCORE_END) begin
            r = PLAYER_ROW;
        end
        else begin
            r = LAMP_RW'({a[1:0], a[3]});
        end
        return r;
    endfunction

endpackage

FILE: design/rmdl_ram.sv
module rmdl_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/rmdl_lamp_mem.sv
module rmdl_lamp_mem
    import rmdl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [LAMP_RW-1:0] rd_row,
    input  lamp_wr_t           wr,
    output logic [LAMP_DW-1:0] rd_data
);

    logic [LAMP_DW-1:0]   mem [LAMP_ROWS];
    logic [LAMP_ROWS-1:0] row_valid_reg;
    logic [LAMP_DW-1:0]   rd_data_reg;
    logic [LAMP_DW-1:0]   fwd_data_reg;
    logic                 rd_ok_reg;
    logic                 fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en) begin
            mem[wr.row] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_valid_reg <= '0;
            rd_ok_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else begin
            if (wr.en) begin
                row_valid_reg[wr.row] <= 1'b1;
            end
            if (rd_en) begin
                rd_ok_reg <= row_valid_reg[rd_row];
                fwd_hit_reg <= wr.en && (wr.row == rd_row);
            end
        end
    end

    // A write landing in the same cycle as the read of that row is forwarded.
    always_comb
    begin
        if (fwd_hit_reg) begin
            rd_data = fwd_data_reg;
        end
        else if (rd_ok_reg) begin
            rd_data = rd_data_reg;
        end
        else begin
            rd_data = '0;
        end
    end

endmodule

FILE: design/rmdl_decode.sv
module rmdl_decode
    import rmdl_pkg::*;
(
    input  req_t               req,
    input  logic [DATA_W-1:0]  ram_rdata,
    input  logic [LAMP_DW-1:0] lamp_rdata,
    output rsp_t               rsp,
    output lamp_wr_t           lamp_wr
);

    logic [ADDR_W-1:0] a;
    logic [3:0]        lo;
    logic [3:0]        hi;
    logic [7:0]        old_lo;
    logic [7:0]        old_hi;
    logic [7:0]        new_lo;
    logic [7:0]        new_hi;
    logic [7:0]        pbit;

    assign a = req.address;
    assign lo = req.write_data[3:0];
    assign hi = req.write_data[7:4];
    assign old_lo = lamp_rdata[7:0];
    assign old_hi = lamp_rdata[15:8];
    assign pbit = PLAYER_BIT0 >> a[3:2];

    always_comb
    begin
        rsp = '0;
        lamp_wr = '0;
        new_lo = old_lo;
        new_hi = old_hi;
        if (req.req_type == REQ_READ) begin
            rsp.read_data = ram_rdata;
        end
        else if (a < SCORE_END) begin
            if (a[1:0] == 2'b11) begin
                if (lo == PLAYER_ON_CODE) begin
                    new_lo = old_lo | pbit;
                end
                else begin
                    new_lo = old_lo & ~pbit;
                end
                rsp.lamp_update = 1'b1;
                rsp.lamp_column = PLAYER_COL;
                rsp.lamp_value = new_lo;
                lamp_wr.en = 1'b1;
                lamp_wr.row = PLAYER_ROW;
                lamp_wr.data = {8'h00, new_lo};
            end
            else begin
                rsp.disp_update = 1'b1;
                rsp.disp_position = SCORE_POS_TOP - {1'b0, a[3:0], 1'b0};
                rsp.disp_first_digit = hi;
                rsp.disp_second_digit = lo;
            end
        end
        else if (a == MATCH_ADDR || a == CREDIT_ADDR) begin
            rsp.disp_update = 1'b1;
            rsp.disp_position = (a == MATCH_ADDR) ? MATCH_POS : CREDIT_POS;
            rsp.disp_first_digit = hi;
            rsp.disp_second_digit = lo;
        end
        else if (a >= LAMP_BASE && a < LAMP_END) begin
            if (!a[2]) begin
                new_lo = {old_lo[7:4], lo};
                new_hi = {old_hi[7:4], hi};
            end
            else begin
                new_lo = {lo, old_lo[3:0]};
                new_hi = {hi, old_hi[3:0]};
            end
            rsp.lamp_update = 1'b1;
            rsp.lamp_column = {2'b00, a[1:0], a[3]};
            rsp.lamp_value = new_lo;
            rsp.lamp_pair = 1'b1;
            rsp.lamp_upper_value = new_hi;
            lamp_wr.en = 1'b1;
            lamp_wr.row = lamp_row(a);
            lamp_wr.data = {new_hi, new_lo};
        end
    end

endmodule

FILE: design/ram_mapped_display_lamp_decoder.sv
// Channel   Valid      Stall      Payload
// request   req_valid  req_stall  req (req_t)
// response  rsp_valid  rsp_stall  rsp (rsp_t)
//
// Each request passes through the s1 register and then the response register, and one request
// can be accepted every cycle while req_stall is low. The work RAM read and the lamp row read
// are registered, and the lamp row is written back when the request leaves s1.
// After reset the block clears all 512 work RAM words and holds req_stall high.
// A stalled response holds the request in flight, so at most two are buffered.
module ram_mapped_display_lamp_decoder
    import rmdl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic              clearing_reg;
    logic [RAM_AW-1:0] clear_addr_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    req_t              s1_req_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_t              out_reg;

    logic [ADDR_W-1:0]  req_addr;
    logic               accept;
    logic               s1_move;
    logic               ram_en;
    logic               ram_we;
    logic [RAM_AW-1:0]  ram_addr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [DATA_W-1:0]  ram_rdata;
    logic [LAMP_DW-1:0] lamp_rdata;
    lamp_wr_t           dec_wr;
    lamp_wr_t           lamp_wr;
    rsp_t               dec_rsp;

    assign req_addr = reduce_addr(req.address);
    assign s1_move = s1_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = clearing_reg || (s1_valid_reg && !s1_move);
    assign accept = req_valid && !req_stall;

    assign ram_en = clearing_reg || accept;
    assign ram_we = clearing_reg || (req.req_type == REQ_WRITE);
    assign ram_addr = clearing_reg ? clear_addr_reg : req_addr[RAM_AW-1:0];
    assign ram_wdata = clearing_reg ? '0 : req.write_data;

    rmdl_ram #(
        .DEPTH(RAM_DEPTH),
        .WIDTH(DATA_W)
    ) u_ram (
        .clk(clk),
        .en(ram_en),
        .we(ram_we),
        .addr(ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        lamp_wr = dec_wr;
        lamp_wr.en = dec_wr.en && s1_move;
    end

    rmdl_lamp_mem u_lamp (
        .clk(clk),
        .rst_n(rst_n),
        .rd_en(accept),
        .rd_row(lamp_row(req_addr)),
        .wr(lamp_wr),
        .rd_data(lamp_rdata)
    );

    rmdl_decode u_decode (
        .req(s1_req_reg),
        .ram_rdata(ram_rdata),
        .lamp_rdata(lamp_rdata),
        .rsp(dec_rsp),
        .lamp_wr(dec_wr)
    );

    always_comb
    begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
        else begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_move) begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clearing_reg <= 1'b1;
            clear_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (clearing_reg) begin
                if (clear_addr_reg == RAM_AW'(RAM_DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
                else begin
                    clear_addr_reg <= clear_addr_reg + 1'b1;
                end
            end
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_req_reg <= '{req_type: req.req_type, address: req_addr,
                            write_data: req.write_data};
        end
        if (s1_move) begin
            out_reg <= dec_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> $past(clear_addr_reg) == RAM_AW'(RAM_DEPTH - 1))
        else $error("Clearing pass ended early.");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_req_reg))
        else $error("Request in flight was lost.");

    a_one_effect: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.disp_update && rsp.lamp_update))
        else $error("Response drives display and lamps together.");

    a_pair_col: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.lamp_pair |-> rsp.lamp_update && rsp.lamp_column < 5'd8)
        else $error("Paired lamp update on a bad column.");

endmodule
